[hdl/chol_pkg.sv]
// Shared types and constants for the Cholesky factor block.
package chol_pkg;

  localparam int unsigned MaxOrder = 8;
  localparam int unsigned IdxW     = $clog2(MaxOrder);
  localparam int unsigned AddrW    = 2 * IdxW;
  localparam int unsigned Depth    = MaxOrder * MaxOrder;

  // Result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadInput = 2'd1;
  localparam logic [1:0] StatusBadPivot = 2'd2;
  localparam logic [1:0] StatusUnused   = 2'd3;

  // Sequencer states, one-hot
  typedef enum logic [14:0] {
    StLoad    = 15'b000000000000001,
    StCkRd    = 15'b000000000000010,
    StCkCmp   = 15'b000000000000100,
    StFaRd    = 15'b000000000001000,
    StFaAcc   = 15'b000000000010000,
    StMacRd   = 15'b000000000100000,
    StMacMul  = 15'b000000001000000,
    StMacSub  = 15'b000000010000000,
    StFinish  = 15'b000000100000000,
    StDecide  = 15'b000001000000000,
    StIter    = 15'b000010000000000,
    StOutRd   = 15'b000100000000000,
    StOutLd   = 15'b001000000000000,
    StOutWait = 15'b010000000000000,
    StErrWait = 15'b100000000000000
  } state_e;

  // Request to the shared square-root / divide unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [31:0] operand;
    logic [31:0] divisor;
  } iter_req_t;

endpackage

[hdl/chol_if.sv]
// Valid/ready channel interfaces for matrix entries and factor results.
interface chol_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] matrix_entry;
  modport source (output valid, output matrix_entry, input ready);
  modport sink (input valid, input matrix_entry, output ready);
endinterface

interface chol_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] factor_value;
  logic [2:0]         row_index;
  logic [2:0]         col_index;
  logic [1:0]         status;
  logic               last_flag;
  modport source (output valid, output factor_value, output row_index, output col_index,
                  output status, output last_flag, input ready);
  modport sink (input valid, input factor_value, input row_index, input col_index,
                input status, input last_flag, output ready);
endinterface

[hdl/chol_iter.sv]
// Shared bit-serial unit: floor square root of (x << 16) or Q16.16 divide.
module chol_iter
  import chol_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  iter_req_t   req_i,
  output logic        done_o,
  output logic [31:0] result_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        sqrt_q, sqrt_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] work_q, work_d;
  logic [33:0] rem_q, rem_d;
  logic [47:0] res_q, res_d;
  logic [31:0] div_q, div_d;

  logic [31:0] mag;
  logic [33:0] rem_n, trial;
  logic        ge;
  logic        big;

  // Operand magnitude for the divide
  assign mag = req_i.operand[31] ? (~req_i.operand + 32'd1) : req_i.operand;

  // One result bit per cycle
  always_comb begin
    if (sqrt_q) begin
      rem_n = {rem_q[31:0], work_q[47:46]};
      trial = {res_q[31:0], 2'b01};
    end else begin
      rem_n = {rem_q[32:0], work_q[47]};
      trial = {2'b00, div_q};
    end
    ge = (rem_n >= trial);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    res_d  = res_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      sqrt_d = req_i.is_sqrt;
      neg_d  = req_i.operand[31];
      cnt_d  = req_i.is_sqrt ? 6'd23 : 6'd47;
      work_d = req_i.is_sqrt ? {req_i.operand, 16'h0000} : {mag, 16'h0000};
      rem_d  = '0;
      res_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_n - trial) : rem_n;
      res_d  = {res_q[46:0], ge};
      work_d = sqrt_q ? {work_q[45:0], 2'b00} : {work_q[46:0], 1'b0};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    work_q <= work_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    div_q  <= div_d;
  end

  // Quotient clamp and sign
  assign big = |res_q[47:31];
  always_comb begin
    if (sqrt_q) begin
      result_o = res_q[31:0];
    end else if (neg_q) begin
      result_o = big ? 32'h8000_0000 : (~res_q[31:0] + 32'd1);
    end else begin
      result_o = big ? 32'h7FFF_FFFF : res_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

[hdl/cholesky_llt_factor.sv]
// Cholesky LLT factor: loads an n-by-n Q16.16 matrix, emits its lower factor L.
// Loading takes one entry per cycle; the factor run then follows before the next load.
// A check pass reads every entry pair; each L entry then runs a MAC over the earlier columns, then
// a pivot test and the shared bit-serial unit (square root on the diagonal, divide off it).
// Each result is read, loaded, then held until taken; an error gives one result.
// Reset (rst_ni low, asynchronous) returns to loading at entry (0,0) with order 8.
module cholesky_llt_factor
  import chol_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  chol_in_if.sink          entry_i,
  chol_out_if.source       factor_o
);

  state_e state_q, state_d;

  logic [3:0]      order_q;
  logic [IdxW-1:0] n_m1;
  logic [IdxW-1:0] lr_q, lr_d, lc_q, lc_d;
  logic [IdxW-1:0] ci_q, ci_d, cj_q, cj_d, ck_q, ck_d;
  logic            ok_q, ok_d;

  // Matrix and factor memories
  logic signed [31:0] a_mem [Depth];
  logic signed [31:0] l_mem [Depth];
  logic [AddrW-1:0]   a_addr_a, a_addr_b, l_addr_a, l_addr_b;
  logic signed [31:0] a_rda_q, a_rdb_q, l_rda_q, l_rdb_q;
  logic               l_we;
  logic [31:0]        l_wdata;

  logic signed [31:0] acc_q, acc_d;
  logic signed [63:0] prod_q;
  logic signed [63:0] prod_r;
  logic signed [49:0] diff;
  logic signed [31:0] diff_sat;

  iter_req_t   iter_req;
  logic        iter_done;
  logic [31:0] iter_res;

  // Output register
  logic        ov_q, ov_d;
  logic [31:0] oval_q, oval_d;
  logic [2:0]  orow_q, orow_d, ocol_q, ocol_d;
  logic [1:0]  ost_q, ost_d;
  logic        olast_q, olast_d;

  logic in_acc, out_acc, ck_fail;

  assign n_m1 = (order_q == 4'd0) ? '0 :
                (order_q > 4'(MaxOrder)) ? IdxW'(MaxOrder - 1) : IdxW'(order_q - 4'd1);

  assign entry_i.ready = (state_q == StLoad);
  assign in_acc  = entry_i.valid && entry_i.ready;
  assign out_acc = ov_q && factor_o.ready;

  // Read address selection
  always_comb begin
    a_addr_a = {ci_q, cj_q};
    a_addr_b = {cj_q, ci_q};
    l_addr_a = {ci_q, cj_q};
    l_addr_b = {cj_q, cj_q};
    if (state_q == StMacRd) begin
      l_addr_a = {ci_q, ck_q};
      l_addr_b = {cj_q, ck_q};
    end
  end

  // Matrix store: written while loading
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_mem[{lr_q, lc_q}] <= entry_i.matrix_entry;
    end
    a_rda_q <= a_mem[a_addr_a];
    a_rdb_q <= a_mem[a_addr_b];
  end

  // Factor store
  always_ff @(posedge clk_i) begin
    if (l_we) begin
      l_mem[{ci_q, cj_q}] <= l_wdata;
    end
    l_rda_q <= l_mem[l_addr_a];
    l_rdb_q <= l_mem[l_addr_b];
  end

  // Rounded product subtract with saturation
  assign prod_r = prod_q + 64'sd32768;
  assign diff   = {{18{acc_q[31]}}, acc_q} - {{2{prod_r[63]}}, prod_r[63:16]};
  always_comb begin
    if (!diff[49] && (|diff[48:31])) begin
      diff_sat = 32'sh7FFF_FFFF;
    end else if (diff[49] && !(&diff[48:31])) begin
      diff_sat = 32'sh8000_0000;
    end else begin
      diff_sat = diff[31:0];
    end
  end

  assign ck_fail = (a_rda_q != a_rdb_q) || ((ci_q == cj_q) && (a_rda_q <= 32'sd0));

  chol_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (iter_req),
    .done_o   (iter_done),
    .result_o (iter_res)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    lr_d     = lr_q;
    lc_d     = lc_q;
    ci_d     = ci_q;
    cj_d     = cj_q;
    ck_d     = ck_q;
    ok_d     = ok_q;
    acc_d    = acc_q;
    ov_d     = ov_q;
    oval_d   = oval_q;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    ost_d    = ost_q;
    olast_d  = olast_q;
    l_we     = 1'b0;
    l_wdata  = iter_res;
    iter_req = '{start: 1'b0, is_sqrt: (ci_q == cj_q), operand: acc_q, divisor: l_rdb_q};
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (lc_q == n_m1) begin
            lc_d = '0;
            if (lr_q == n_m1) begin
              lr_d    = '0;
              ci_d    = '0;
              cj_d    = '0;
              ok_d    = 1'b1;
              state_d = StCkRd;
            end else begin
              lr_d = lr_q + 1'b1;
            end
          end else begin
            lc_d = lc_q + 1'b1;
          end
        end
        if (cfg_we_i) begin
          lr_d = '0;
          lc_d = '0;
        end
      end
      StCkRd: state_d = StCkCmp;
      StCkCmp: begin
        ok_d    = ok_q && !ck_fail;
        state_d = StCkRd;
        if (cj_q == n_m1) begin
          cj_d = '0;
          if (ci_q == n_m1) begin
            ci_d = '0;
            if (ok_d) begin
              state_d = StFaRd;
            end else begin
              ov_d    = 1'b1;
              oval_d  = '0;
              orow_d  = '0;
              ocol_d  = '0;
              ost_d   = StatusBadInput;
              olast_d = 1'b1;
              state_d = StErrWait;
            end
          end else begin
            ci_d = ci_q + 1'b1;
          end
        end else begin
          cj_d = cj_q + 1'b1;
        end
      end
      StFaRd: state_d = StFaAcc;
      StFaAcc: begin
        acc_d   = a_rda_q;
        ck_d    = '0;
        state_d = (cj_q == '0) ? StFinish : StMacRd;
      end
      StMacRd:  state_d = StMacMul;
      StMacMul: state_d = StMacSub;
      StMacSub: begin
        acc_d = diff_sat;
        if (ck_q + 1'b1 == cj_q) begin
          state_d = StFinish;
        end else begin
          ck_d    = ck_q + 1'b1;
          state_d = StMacRd;
        end
      end
      StFinish: state_d = StDecide;
      StDecide: begin
        if ((ci_q == cj_q) && (acc_q <= 32'sd0)) begin
          ov_d    = 1'b1;
          oval_d  = '0;
          orow_d  = '0;
          ocol_d  = '0;
          ost_d   = StatusBadPivot;
          olast_d = 1'b1;
          state_d = StErrWait;
        end else begin
          iter_req.start = 1'b1;
          state_d        = StIter;
        end
      end
      StIter: begin
        if (iter_done) begin
          l_we    = 1'b1;
          state_d = StFaRd;
          if (cj_q == ci_q) begin
            cj_d = '0;
            if (ci_q == n_m1) begin
              ci_d    = '0;
              state_d = StOutRd;
            end else begin
              ci_d = ci_q + 1'b1;
            end
          end else begin
            cj_d = cj_q + 1'b1;
          end
        end
      end
      StOutRd: state_d = StOutLd;
      StOutLd: begin
        ov_d    = 1'b1;
        oval_d  = (cj_q > ci_q) ? 32'd0 : l_rda_q;
        orow_d  = 3'(ci_q);
        ocol_d  = 3'(cj_q);
        ost_d   = StatusOk;
        olast_d = (ci_q == n_m1) && (cj_q == n_m1);
        state_d = StOutWait;
      end
      StOutWait: begin
        if (out_acc) begin
          ov_d    = 1'b0;
          state_d = StOutRd;
          if (cj_q == n_m1) begin
            cj_d = '0;
            if (ci_q == n_m1) begin
              ci_d    = '0;
              state_d = StLoad;
            end else begin
              ci_d = ci_q + 1'b1;
            end
          end else begin
            cj_d = cj_q + 1'b1;
          end
        end
      end
      StErrWait: begin
        if (out_acc) begin
          ov_d    = 1'b0;
          ci_d    = '0;
          cj_d    = '0;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      order_q <= 4'(MaxOrder);
      lr_q    <= '0;
      lc_q    <= '0;
      ci_q    <= '0;
      cj_q    <= '0;
      ck_q    <= '0;
      ok_q    <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      lr_q <= lr_d;
      lc_q <= lc_d;
      ci_q <= ci_d;
      cj_q <= cj_d;
      ck_q <= ck_d;
      ok_q <= ok_d;
      ov_q <= ov_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= l_rda_q * l_rdb_q;
    oval_q  <= oval_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    ost_q   <= ost_d;
    olast_q <= olast_d;
  end

  assign factor_o.valid        = ov_q;
  assign factor_o.factor_value = oval_q;
  assign factor_o.row_index    = orow_q;
  assign factor_o.col_index    = ocol_q;
  assign factor_o.status       = ost_q;
  assign factor_o.last_flag    = olast_q;

`ifndef SYNTHESIS
  // No result is pending while entries are being loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> !ov_q)
    else $error("result pending during load");

  // The last entry of a load starts the check pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_we_i && (lr_q == n_m1) && (lc_q == n_m1)) |=> (state_q == StCkRd))
    else $error("full load did not start check");

  // Taking the final result returns to loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && olast_q) |=> (state_q == StLoad))
    else $error("run did not end after last result");

  // A pending result never carries the unused status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ost_q != StatusUnused))
    else $error("bad status code");
`endif

endmodule

[tb/tb_cholesky_llt_factor.sv]
// Self-checking testbench for the Cholesky LLT factor block.
module tb_cholesky_llt_factor;
  import chol_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  chol_in_if  entry_if ();
  chol_out_if factor_if ();

  cholesky_llt_factor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .entry_i     (entry_if.sink),
    .factor_o    (factor_if.source)
  );

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         row;
    logic [2:0]         col;
    logic [1:0]         status;
    logic               last;
  } factor_t;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  // Predictor state
  logic [3:0]         order_reg;
  logic signed [31:0] entry_store [Depth];
  int unsigned        entry_count;

  logic signed [31:0] entry_queue [$];
  factor_t            factor_queue [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_cnt;
  int unsigned result_cnt;
  int unsigned matrix_cnt;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sat32(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  // Q16.16 product, round to nearest with ties toward plus infinity
  function automatic longint qmul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned active_order();
    if (order_reg == 0) return 1;
    if (order_reg > MaxOrder) return MaxOrder;
    return order_reg;
  endfunction

  function automatic void push_error(logic [1:0] st);
    factor_t r;
    r = '{value: '0, row: '0, col: '0, status: st, last: 1'b1};
    factor_queue.push_back(r);
  endfunction

  // Factor the stored matrix and queue the expected results
  function automatic void predict_factor();
    int unsigned        n;
    longint             lf [MaxOrder][MaxOrder];
    longint             acc;
    longint unsigned    mag;
    longint unsigned    q;
    bit                 ok;
    factor_t            r;
    n = active_order();
    ok = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (entry_store[i*n+i] <= 0) ok = 1'b0;
      for (int j = 0; j < n; j++)
        if (entry_store[i*n+j] != entry_store[j*n+i]) ok = 1'b0;
    end
    if (!ok) begin
      push_error(StatusBadInput);
      return;
    end
    for (int i = 0; i < MaxOrder; i++)
      for (int j = 0; j < MaxOrder; j++) lf[i][j] = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j <= i; j++) begin
        acc = entry_store[i*n+j];
        for (int k = 0; k < j; k++) acc = sat32(acc - qmul(lf[i][k], lf[j][k]));
        if (i == j) begin
          if (acc <= 0) begin
            push_error(StatusBadPivot);
            return;
          end
          lf[i][i] = longint'(isqrt(longint'(acc) << 16));
        end else begin
          mag = (acc < 0) ? longint'(-acc) : longint'(acc);
          q = (mag << 16) / longint'(lf[j][j]);
          if (q > 64'd2147483648) q = 64'd2147483648;
          lf[i][j] = sat32((acc < 0) ? -longint'(q) : longint'(q));
        end
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        r.value  = lf[i][j][31:0];
        r.row    = i[2:0];
        r.col    = j[2:0];
        r.status = StatusOk;
        r.last   = (i*n + j == n*n - 1);
        factor_queue.push_back(r);
      end
  endfunction

  function automatic void predict_entry(logic signed [31:0] e);
    int unsigned total;
    total = active_order() * active_order();
    if (entry_count >= total) entry_count = 0;
    entry_store[entry_count] = e;
    entry_count++;
    if (entry_count == total) begin
      entry_count = 0;
      matrix_cnt++;
      predict_factor();
    end
  endfunction

  // Driver: present pending entries with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_if.valid        <= 1'b0;
      entry_if.matrix_entry <= '0;
    end else begin
      if (entry_if.valid && entry_if.ready) begin
        predict_entry(entry_queue.pop_front());
      end
      if ((!entry_if.valid || entry_if.ready) && entry_queue.size() > 0 &&
          entry_queue.size() > (entry_if.valid && entry_if.ready ? 0 : 0)) begin
        if (entry_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          entry_if.valid        <= 1'b1;
          entry_if.matrix_entry <= entry_queue[0];
        end else begin
          entry_if.valid <= 1'b0;
        end
      end else if (entry_if.valid && entry_if.ready) begin
        entry_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and compare of every result field
  always @(posedge clk_i or negedge rst_ni) begin
    factor_t got;
    factor_t want;
    if (!rst_ni) begin
      factor_if.ready <= 1'b0;
    end else begin
      if (factor_if.valid && factor_if.ready) begin
        got = '{factor_if.factor_value, factor_if.row_index, factor_if.col_index,
                factor_if.status, factor_if.last_flag};
        result_cnt++;
        if (factor_queue.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10) $display("unexpected result %p", got);
        end else begin
          want = factor_queue.pop_front();
          if (got !== want) begin
            error_cnt++;
            if (error_cnt <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      factor_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (entry_queue.size() != 0 || entry_if.valid || factor_queue.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_order(logic [3:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    order_reg   = v;
    entry_count = 0;
  endtask

  function automatic logic signed [31:0] rand_entry();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h0000_ffff));
    endcase
  endfunction

  // Queue a symmetric, diagonal-heavy matrix (mostly factors cleanly)
  task automatic queue_spd(int unsigned n);
    logic signed [31:0] m [MaxOrder][MaxOrder];
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++) begin
        m[i][j] = (i == j) ? $signed($urandom_range(32'h0080_0000, 32'h0001_0000))
                           : $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
        if ($urandom_range(9) == 0) m[i][j] = rand_entry();
        m[j][i] = m[i][j];
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) entry_queue.push_back(m[i][j]);
  endtask

  task automatic queue_noise(int unsigned cnt);
    repeat (cnt) entry_queue.push_back(rand_entry());
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned n;
    int unsigned sent;
    sent = 0;
    while (sent < items) begin
      n = active_order();
      if ($urandom_range(4) == 0) queue_noise(n * n);
      else queue_spd(n);
      sent += n * n;
      wait_drained();
    end
  endtask

  // Stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    order_reg      = 4'd8;
    entry_count    = 0;
    error_cnt      = 0;
    result_cnt     = 0;
    matrix_cnt     = 0;
    send_idle_pct  = 30;
    recv_idle_pct  = 58;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: order 1 extremes, positive, zero and negative diagonal
    write_order(4'd1);
    entry_queue.push_back(32'sh7fff_ffff);
    entry_queue.push_back(32'sh0000_0001);
    entry_queue.push_back(32'sh0000_0000);
    entry_queue.push_back(32'sh8000_0000);
    wait_drained();
    // Order 2: asymmetric, nonpositive pivot, clean, then order 0 acting as 1
    write_order(4'd2);
    entry_queue.push_back(32'sh0001_0000); entry_queue.push_back(32'sh0000_0001);
    entry_queue.push_back(32'sh0000_0002); entry_queue.push_back(32'sh0001_0000);
    entry_queue.push_back(32'sh0001_0000); entry_queue.push_back(32'sh0002_0000);
    entry_queue.push_back(32'sh0002_0000); entry_queue.push_back(32'sh0001_0000);
    entry_queue.push_back(32'sh0004_0000); entry_queue.push_back(32'shfffe_0000);
    entry_queue.push_back(32'shfffe_0000); entry_queue.push_back(32'sh0005_0000);
    wait_drained();
    // Partial load abandoned by an order write
    entry_queue.push_back(32'sh1234_5678);
    wait_drained();
    write_order(4'd0);
    entry_queue.push_back(32'sh0009_0000);
    wait_drained();
    write_order(4'd15);
    queue_spd(8);
    wait_drained();

    // Random phases across orders and idling profiles
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 30 : (p == 1) ? 58 : 0;
      recv_idle_pct = (p == 0) ? 58 : (p == 1) ? 30 : 0;
      write_order(4'($urandom_range(2, 4)));
      run_phase(25);
      write_order(4'd3);
      run_phase(20);
      write_order(4'($urandom_range(5, 8)));
      run_phase(10);
    end

    wait_drained();
    $display("Factored %0d matrices of order 0..15 settings, %0d results checked.",
             matrix_cnt, result_cnt);
    if (error_cnt == 0) begin
      $display("tb_cholesky_llt_factor OK");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("tb_cholesky_llt_factor NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("timeout");
    $display("tb_cholesky_llt_factor NOT OK");
    $finish;
  end

endmodule
